[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent checks on clk, switched off while arst_n is low.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[src/dcvag_pkg.sv]
package dcvag_pkg;

	localparam int BLOCK_PAIRS     = 4096;
	localparam int CH1_CHUNK_BYTES = 32768;
	localparam int CH2_CHUNK_BYTES = 65536;
	localparam int HANG_BLOCKS     = 7;

	localparam int SAMPLE_W    = 8;
	localparam int LEVEL_W     = 8;
	localparam int THR_W       = 8;
	localparam int EVT_W       = 2;
	localparam int CH1_COUNT_W = 16;
	localparam int CH2_COUNT_W = 17;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;

	localparam int ABS_W       = SAMPLE_W;
	localparam int IDX_W       = $clog2(BLOCK_PAIRS);
	localparam int BLOCK_SHIFT = $clog2(BLOCK_PAIRS);
	localparam int SUM_W       = $clog2(BLOCK_PAIRS * (2 ** (SAMPLE_W - 1)) + 2);
	localparam int HANG_W      = $clog2(HANG_BLOCKS + 2);
	localparam int CH1_BYTES_W = $clog2(CH1_CHUNK_BYTES + BLOCK_PAIRS);
	localparam int CH2_BYTES_W = $clog2(CH2_CHUNK_BYTES + BLOCK_PAIRS);
	localparam int BYTES_W     = (CH1_BYTES_W > CH2_BYTES_W) ? CH1_BYTES_W : CH2_BYTES_W;

	typedef enum logic [EVT_W-1:0] {
		EV_NONE       = 2'd0,
		EV_CHUNK_FULL = 2'd1,
		EV_CLOSED     = 2'd2
	} gate_evt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CH1_THR = 2'd0,
		REG_CH2_THR = 2'd1,
		REG_CH2_DIS = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] ch1_sample;
		logic signed [SAMPLE_W-1:0] ch2_sample;
	} sample_t;

	typedef struct packed {
		logic [LEVEL_W-1:0]     ch1_level;
		logic [LEVEL_W-1:0]     ch2_level;
		gate_evt_t              ch1_event;
		logic [CH1_COUNT_W-1:0] ch1_count;
		gate_evt_t              ch2_event;
		logic [CH2_COUNT_W-1:0] ch2_count;
		logic                   ch1_active;
		logic                   ch2_active;
	} result_t;

	typedef struct packed {
		logic [HANG_W-1:0]  hang;
		logic               started;
		logic               close;
		gate_evt_t          evt;
		logic [BYTES_W-1:0] count;
	} gate_res_t;

	function automatic logic [ABS_W-1:0] abs_sample(input logic signed [SAMPLE_W-1:0] s);
		logic [ABS_W-1:0] u;
		u = ABS_W'(s);
		return u[ABS_W-1] ? (~u + 1'b1) : u;
	endfunction

	function automatic gate_res_t gate_step(
		input logic [LEVEL_W-1:0] level,
		input logic [THR_W-1:0]   thr,
		input logic [BYTES_W-1:0] bytes,
		input logic [HANG_W-1:0]  hang,
		input logic               started,
		input logic [BYTES_W-1:0] chunk
	);
		gate_res_t r;
		r.hang    = hang;
		r.started = started;
		r.close   = 1'b0;
		r.evt     = EV_NONE;
		r.count   = '0;
		if (level < thr) begin
			r.hang    = '0;
			r.started = 1'b1;
		end else if (hang > HANG_W'(HANG_BLOCKS)) begin
			r.hang    = '0;
			r.started = 1'b0;
			r.close   = 1'b1;
			r.evt     = EV_CLOSED;
			r.count   = bytes;
		end else if (started) begin
			r.hang = hang + 1'b1;
		end
		if (r.started && bytes >= chunk) begin
			r.evt = EV_CHUNK_FULL;
		end
		return r;
	endfunction

endpackage

[src/dual_channel_voice_activity_gate.sv]
// A block's last pair is loaded into the input register, then updates state and loads the result
// register; a stalled full result register can hold that pair in the input register.
// Throughput: one sample pair per cycle; the input stage holds only when a block's last
// pair meets a full result register that is stalled.
// Reset (arst_n low, asynchronous): pair index, byte and hangover counts and capture
// flags clear, sums load one, valid flags and configuration registers clear.
`include "assert_macros.svh"

module dual_channel_voice_activity_gate
	import dcvag_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  sample_t               sample,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [THR_W-1:0]       ch1_thr_q;
	logic [THR_W-1:0]       ch2_thr_q;
	logic                   ch2_dis_q;

	logic                   valid_s1;
	sample_t                sample_s1;

	logic [IDX_W-1:0]       pair_index_q;
	logic [SUM_W-1:0]       ch1_sum_q;
	logic [SUM_W-1:0]       ch2_sum_q;
	logic [CH1_BYTES_W-1:0] ch1_bytes_q;
	logic [CH2_BYTES_W-1:0] ch2_bytes_q;
	logic [HANG_W-1:0]      ch1_hang_q;
	logic [HANG_W-1:0]      ch2_hang_q;
	logic                   ch1_started_q;
	logic                   ch2_started_q;

	logic                   result_valid_q;
	result_t                result_q;

	logic                   first;
	logic                   last;
	logic                   go;
	logic [SUM_W-1:0]       ch1_sum_new;
	logic [SUM_W-1:0]       ch2_sum_new;
	logic [CH1_BYTES_W-1:0] ch1_bytes_new;
	logic [CH2_BYTES_W-1:0] ch2_bytes_new;
	logic [LEVEL_W-1:0]     ch1_level;
	logic [LEVEL_W-1:0]     ch2_level;
	gate_res_t              g1;
	gate_res_t              g2;
	result_t                result_d;

	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign first        = (pair_index_q == '0);
	assign last         = (pair_index_q == IDX_W'(BLOCK_PAIRS - 1));
	assign go           = valid_s1 && (!last || !result_valid_q || !result_stall);
	assign sample_stall = valid_s1 && !go;

	always_comb begin
		ch1_sum_new = ch1_sum_q + SUM_W'(abs_sample(sample_s1.ch1_sample));
		ch2_sum_new = ch2_sum_q + SUM_W'(abs_sample(sample_s1.ch2_sample));

		if (first && (ch1_bytes_q >= CH1_BYTES_W'(CH1_CHUNK_BYTES) || !ch1_started_q)) begin
			ch1_bytes_new = CH1_BYTES_W'(1);
		end else begin
			ch1_bytes_new = ch1_bytes_q + 1'b1;
		end
		if (first && (ch2_bytes_q >= CH2_BYTES_W'(CH2_CHUNK_BYTES) || !ch2_started_q)) begin
			ch2_bytes_new = CH2_BYTES_W'(1);
		end else begin
			ch2_bytes_new = ch2_bytes_q + 1'b1;
		end

		ch1_level = LEVEL_W'(ch1_sum_new >> BLOCK_SHIFT);
		ch2_level = LEVEL_W'(ch2_sum_new >> BLOCK_SHIFT);

		g1 = gate_step(ch1_level, ch1_thr_q, BYTES_W'(ch1_bytes_new), ch1_hang_q,
			ch1_started_q, BYTES_W'(CH1_CHUNK_BYTES));
		g2 = gate_step(ch2_level, ch2_thr_q, BYTES_W'(ch2_bytes_new), ch2_hang_q,
			ch2_started_q, BYTES_W'(CH2_CHUNK_BYTES));

		result_d.ch1_level  = ch1_level;
		result_d.ch2_level  = ch2_level;
		result_d.ch1_event  = g1.evt;
		result_d.ch1_count  = CH1_COUNT_W'(g1.count);
		result_d.ch1_active = g1.started;
		if (ch2_dis_q) begin
			result_d.ch2_event  = EV_NONE;
			result_d.ch2_count  = '0;
			result_d.ch2_active = ch2_started_q;
		end else begin
			result_d.ch2_event  = g2.evt;
			result_d.ch2_count  = CH2_COUNT_W'(g2.count);
			result_d.ch2_active = g2.started;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch1_thr_q <= '0;
			ch2_thr_q <= '0;
			ch2_dis_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CH1_THR: ch1_thr_q <= THR_W'(cfg_data);
				REG_CH2_THR: ch2_thr_q <= THR_W'(cfg_data);
				REG_CH2_DIS: ch2_dis_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_index_q  <= '0;
			ch1_sum_q     <= SUM_W'(1);
			ch2_sum_q     <= SUM_W'(1);
			ch1_bytes_q   <= '0;
			ch2_bytes_q   <= '0;
			ch1_hang_q    <= '0;
			ch2_hang_q    <= '0;
			ch1_started_q <= 1'b0;
			ch2_started_q <= 1'b0;
		end else if (go) begin
			if (!last) begin
				pair_index_q <= pair_index_q + 1'b1;
				ch1_sum_q    <= ch1_sum_new;
				ch2_sum_q    <= ch2_sum_new;
				ch1_bytes_q  <= ch1_bytes_new;
				ch2_bytes_q  <= ch2_bytes_new;
			end else begin
				pair_index_q  <= '0;
				ch1_sum_q     <= SUM_W'(1);
				ch2_sum_q     <= SUM_W'(1);
				ch1_hang_q    <= g1.hang;
				ch1_started_q <= g1.started;
				ch1_bytes_q   <= g1.close ? '0 : ch1_bytes_new;
				if (ch2_dis_q) begin
					ch2_bytes_q <= ch2_bytes_new;
				end else begin
					ch2_hang_q    <= g2.hang;
					ch2_started_q <= g2.started;
					ch2_bytes_q   <= g2.close ? '0 : ch2_bytes_new;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (go && last) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && last) begin
			result_q <= result_d;
		end
	end

	`ASSERT_IMPLIES(a_result_at_block_end, $rose(result_valid_q), pair_index_q == '0,
		"result without block end")
	`ASSERT_IMPLIES(a_sum_restart, pair_index_q == '0,
		ch1_sum_q == SUM_W'(1) && ch2_sum_q == SUM_W'(1), "sum not restarted at block start")
	`ASSERT_IMPLIES(a_hang_needs_capture, ch1_hang_q != '0 || ch2_hang_q != '0,
		(ch1_hang_q == '0 || ch1_started_q) && (ch2_hang_q == '0 || ch2_started_q),
		"hangover count while idle")
	`ASSERT_IMPLIES(a_closed_count, result_valid_q && result_q.ch1_event == EV_CLOSED,
		result_q.ch1_count != '0, "closed capture with no bytes")
	`ASSERT_ALWAYS(a_bytes_bound,
		ch1_bytes_q < CH1_BYTES_W'(CH1_CHUNK_BYTES + BLOCK_PAIRS),
		"channel one byte count overrun")

endmodule
